[rtl/bvp_pkg.sv]
// Package for the Boris velocity push pipeline: widths, payload structs and
// the rounding and saturation helpers used by the datapath modules.
// Depends on nothing.
package bvp_pkg;

	localparam int unsigned Q_W       = 32;
	localparam int unsigned MASS_W    = 31;
	localparam int unsigned TSTEP_W   = 31;
	localparam int unsigned HSTEP_W   = TSTEP_W - 1;
	localparam int unsigned FRAC_W    = 16;
	localparam int unsigned WIDE_W    = 48;
	localparam int unsigned PROD_W    = 64;
	localparam int unsigned DIVN_W    = 66;
	localparam int unsigned DIVD_W    = 33;
	localparam int unsigned QUOT_W    = 32;
	localparam int unsigned DIV_STEPS = QUOT_W;
	localparam int unsigned NUM_W     = DIVN_W - FRAC_W;

	localparam logic [TSTEP_W-1:0] TSTEP_RESET = 31'd65536;

	localparam logic signed [PROD_W-1:0] ONE_Q16  = 64'sd65536;
	localparam logic signed [PROD_W-1:0] HALF_LSB = 64'sd32768;
	localparam logic signed [PROD_W-1:0] MAX_Q16  = 64'sd2147483647;
	localparam logic signed [PROD_W-1:0] MIN_Q16  = -64'sd2147483648;

	typedef logic signed [Q_W-1:0]    q16_t;
	typedef logic signed [WIDE_W-1:0] wide_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic [2:0][Q_W-1:0]      vec_t;
	typedef logic [2:0][WIDE_W-1:0]   wvec_t;

	typedef struct packed {
		vec_t              v;
		vec_t              e;
		vec_t              b;
		q16_t              charge;
		logic [MASS_W-1:0] mass;
	} particle_t;

	typedef struct packed {
		vec_t v;
		vec_t e;
		vec_t b;
		logic zm;
	} coef_side_t;

	typedef struct packed {
		vec_t  v;
		wvec_t ae;
		logic  zm;
	} row_side_t;

	localparam int unsigned SIDE_W = $bits(coef_side_t);
	localparam int unsigned ROW_W  = $bits(row_side_t);

	typedef struct packed {
		logic [DIVN_W-1:0] num;
		logic [DIVD_W-1:0] den;
		logic              neg;
		logic [SIDE_W-1:0] side;
	} div_in_t;

	typedef struct packed {
		q16_t              quot;
		logic [SIDE_W-1:0] side;
	} div_out_t;

	function automatic q16_t sat32(input prod_t x);
		q16_t r;
		if (x > MAX_Q16) begin
			r = MAX_Q16[Q_W-1:0];
		end else if (x < MIN_Q16) begin
			r = MIN_Q16[Q_W-1:0];
		end else begin
			r = x[Q_W-1:0];
		end
		return r;
	endfunction

	function automatic wide_t rnd16(input prod_t p);
		prod_t s;
		s = (p + HALF_LSB) >>> FRAC_W;
		return s[WIDE_W-1:0];
	endfunction

	function automatic prod_t sxq(input q16_t x);
		return prod_t'(x);
	endfunction

	function automatic prod_t sxw(input wide_t x);
		return prod_t'(x);
	endfunction

	function automatic prod_t mulq(input q16_t x, input q16_t y);
		return sxq(x) * sxq(y);
	endfunction

	function automatic q16_t rsat(input prod_t p);
		return sat32(sxw(rnd16(p)));
	endfunction

endpackage

[rtl/bvp_if.sv]
// Channel interfaces of the Boris push block: particle input, velocity
// result and the time step write port. Depends on bvp_pkg.
interface particle_if import bvp_pkg::*; ();
	logic              valid;
	logic              ready;
	q16_t              vel_x;
	q16_t              vel_y;
	q16_t              vel_z;
	q16_t              efield_x;
	q16_t              efield_y;
	q16_t              efield_z;
	q16_t              bfield_x;
	q16_t              bfield_y;
	q16_t              bfield_z;
	q16_t              charge;
	logic [MASS_W-1:0] mass;

	modport source (output valid, vel_x, vel_y, vel_z, efield_x, efield_y, efield_z,
		bfield_x, bfield_y, bfield_z, charge, mass, input ready);
	modport sink (input valid, vel_x, vel_y, vel_z, efield_x, efield_y, efield_z,
		bfield_x, bfield_y, bfield_z, charge, mass, output ready);
endinterface

interface result_if import bvp_pkg::*; ();
	logic valid;
	logic ready;
	q16_t new_vel_x;
	q16_t new_vel_y;
	q16_t new_vel_z;
	logic bad_mass;

	modport source (output valid, new_vel_x, new_vel_y, new_vel_z, bad_mass, input ready);
	modport sink (input valid, new_vel_x, new_vel_y, new_vel_z, bad_mass, output ready);
endinterface

interface cfg_if import bvp_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [TSTEP_W-1:0] time_step;

	modport source (output valid, time_step, input ready);
	modport sink (input valid, time_step, output ready);
endinterface

[rtl/bvp_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with signed
// saturation to Q16.16 and a sideband word carried alongside. Depends on bvp_pkg.
module bvp_div
	import bvp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     adv,
	input  logic     in_valid,
	input  div_in_t  din,
	output logic     out_valid,
	output div_out_t dout
);

	localparam int unsigned REM_W = DIVD_W + 1;

	logic [DIV_STEPS:0]  vld_s;
	logic [REM_W-1:0]    rem_s  [DIV_STEPS+1];
	logic [QUOT_W-1:0]   low_s  [DIV_STEPS+1];
	logic [DIVD_W-1:0]   den_s  [DIV_STEPS+1];
	logic                neg_s  [DIV_STEPS+1];
	logic                ovf_s  [DIV_STEPS+1];
	logic [SIDE_W-1:0]   side_s [DIV_STEPS+1];
	logic [REM_W-1:0]    trial  [DIV_STEPS+1];
	logic                fits   [DIV_STEPS+1];
	logic                vld_q;
	div_out_t            dout_q;
	q16_t                res;
	logic [QUOT_W-1:0]   quot;

	always_comb begin
		trial[0] = '0;
		fits[0]  = 1'b0;
		for (int k = 1; k <= DIV_STEPS; k++) begin
			trial[k] = {rem_s[k-1][REM_W-2:0], low_s[k-1][QUOT_W-1]};
			fits[k]  = trial[k] >= {1'b0, den_s[k-1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_s <= {vld_s[DIV_STEPS-1:0], in_valid};
			vld_q <= vld_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0]  <= din.num[DIVN_W-1:QUOT_W];
			low_s[0]  <= din.num[QUOT_W-1:0];
			den_s[0]  <= din.den;
			neg_s[0]  <= din.neg;
			ovf_s[0]  <= din.num[DIVN_W-1:QUOT_W] >= {1'b0, din.den};
			side_s[0] <= din.side;
			for (int k = 1; k <= DIV_STEPS; k++) begin
				rem_s[k]  <= fits[k] ? trial[k] - {1'b0, den_s[k-1]} : trial[k];
				low_s[k]  <= {low_s[k-1][QUOT_W-2:0], fits[k]};
				den_s[k]  <= den_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				ovf_s[k]  <= ovf_s[k-1];
				side_s[k] <= side_s[k-1];
			end
			dout_q.quot <= res;
			dout_q.side <= side_s[DIV_STEPS];
		end
	end

	always_comb begin
		quot = low_s[DIV_STEPS];
		if (ovf_s[DIV_STEPS]) begin
			res = neg_s[DIV_STEPS] ? MIN_Q16[Q_W-1:0] : MAX_Q16[Q_W-1:0];
		end else if (neg_s[DIV_STEPS]) begin
			res = (quot > MAX_Q16[QUOT_W-1:0] + 32'd1) ? MIN_Q16[Q_W-1:0] : q16_t'(-quot);
		end else begin
			res = quot[QUOT_W-1] ? MAX_Q16[Q_W-1:0] : q16_t'(quot);
		end
	end

	assign out_valid = vld_q;
	assign dout      = dout_q;

`ifndef SYNTHESIS
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[DIV_STEPS] && !ovf_s[DIV_STEPS] && den_s[DIV_STEPS] != '0
		|-> rem_s[DIV_STEPS] < {1'b0, den_s[DIV_STEPS]})
		else $error("Divider remainder is not below the divisor.");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s) && $stable(vld_q))
		else $error("Divider valid bits moved during a stall.");
	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_s[DIV_STEPS] && ovf_s[DIV_STEPS]
		|=> out_valid && (dout.quot == MAX_Q16[Q_W-1:0] || dout.quot == MIN_Q16[Q_W-1:0]))
		else $error("Divider overflow did not saturate.");
`endif

endmodule

[rtl/bvp_coef.sv]
// Front stage: registers the particle and forms charge times half step,
// then presents the coefficient division to the divider. Depends on bvp_pkg.
module bvp_coef
	import bvp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  particle_t          pin,
	input  logic [HSTEP_W-1:0] half_step,
	output logic               out_valid,
	output div_in_t            dout
);

	logic              vld_s1;
	prod_t             prod_s1;
	coef_side_t        side_s1;
	logic [MASS_W-1:0] mass_s1;
	prod_t             mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1    <= sxq(pin.charge) * prod_t'({1'b0, half_step});
			side_s1.v  <= pin.v;
			side_s1.e  <= pin.e;
			side_s1.b  <= pin.b;
			side_s1.zm <= pin.mass == '0;
			mass_s1    <= pin.mass;
		end
	end

	always_comb begin
		mag       = prod_s1[PROD_W-1] ? -prod_s1 : prod_s1;
		dout.num  = {2'b00, mag};
		dout.den  = {1'b0, mass_s1, 1'b0};
		dout.neg  = prod_s1[PROD_W-1];
		dout.side = side_s1;
	end

	assign out_valid = vld_s1;

endmodule

[rtl/bvp_rot.sv]
// Eight-stage datapath for the first kick, the rotation matrix and the
// Cramer numerators, feeding three row dividers. Depends on bvp_pkg.
module bvp_rot
	import bvp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     adv,
	input  logic     in_valid,
	input  div_out_t din,
	output logic     out_valid,
	output div_in_t  d0,
	output div_in_t  d1,
	output div_in_t  d2
);

	coef_side_t cs;
	logic [8:1] vld;

	q16_t  a_s1, a_s2, a_s3, a_s4;
	vec_t  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	vec_t  b_s1, b_s2;
	logic  zm_s1, zm_s2, zm_s3, zm_s4, zm_s5, zm_s6, zm_s7, zm_s8;
	prod_t pae_s1 [3];
	prod_t paa_s1;
	prod_t psq_s1 [6];
	prod_t pba_s1 [3];

	wvec_t ae_s2, ae_s3, ae_s4, ae_s5, ae_s6, ae_s7, ae_s8;
	vec_t  vm_s2, vm_s3, vm_s4, vm_s5;
	q16_t  a2_s2, a2_s3;
	q16_t  sq_s2 [6];
	q16_t  ba_s2 [3];
	q16_t  ba_s3 [3];

	prod_t pcr_s3 [6];
	prod_t pm_s3  [6];
	q16_t  bsq_s3;

	vec_t  c_s4;
	q16_t  m_s4 [9];
	q16_t  m_s5 [9];
	q16_t  m_s6 [9];
	prod_t pden_s4;

	prod_t pac_s5 [3];
	q16_t  den_s5, den_s6, den_s7, den_s8;

	vec_t  rhs_s6;
	prod_t prm_s7 [9];
	logic signed [NUM_W-1:0] num_s8 [3];

	wvec_t ae_c;
	prod_t mb [6];
	prod_t nsum [3];
	logic [NUM_W-1:0] mag [3];
	row_side_t rs;

	assign cs = coef_side_t'(din.side);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ae_c[i] = rnd16(pae_s1[i]);
		end
		for (int k = 0; k < 6; k++) begin
			mb[k] = sxw(rnd16(pm_s3[k]));
		end
		for (int i = 0; i < 3; i++) begin
			nsum[i] = sxw(rnd16(prm_s7[3*i])) + sxw(rnd16(prm_s7[3*i+1]))
				+ sxw(rnd16(prm_s7[3*i+2]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else if (adv) begin
			vld <= {vld[7:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1  <= din.quot;
			v_s1  <= cs.v;
			b_s1  <= cs.b;
			zm_s1 <= cs.zm;
			for (int i = 0; i < 3; i++) begin
				pae_s1[i] <= mulq(din.quot, q16_t'(cs.e[i]));
				pba_s1[i] <= mulq(q16_t'(cs.b[i]), din.quot);
			end
			paa_s1    <= mulq(din.quot, din.quot);
			psq_s1[0] <= mulq(q16_t'(cs.b[0]), q16_t'(cs.b[0]));
			psq_s1[1] <= mulq(q16_t'(cs.b[1]), q16_t'(cs.b[1]));
			psq_s1[2] <= mulq(q16_t'(cs.b[2]), q16_t'(cs.b[2]));
			psq_s1[3] <= mulq(q16_t'(cs.b[0]), q16_t'(cs.b[1]));
			psq_s1[4] <= mulq(q16_t'(cs.b[0]), q16_t'(cs.b[2]));
			psq_s1[5] <= mulq(q16_t'(cs.b[1]), q16_t'(cs.b[2]));

			a_s2  <= a_s1;
			v_s2  <= v_s1;
			b_s2  <= b_s1;
			zm_s2 <= zm_s1;
			ae_s2 <= ae_c;
			for (int i = 0; i < 3; i++) begin
				vm_s2[i] <= sat32(sxq(q16_t'(v_s1[i])) + sxw(ae_c[i]));
				ba_s2[i] <= rsat(pba_s1[i]);
			end
			a2_s2 <= rsat(paa_s1);
			for (int k = 0; k < 6; k++) begin
				sq_s2[k] <= rsat(psq_s1[k]);
			end

			a_s3  <= a_s2;
			a2_s3 <= a2_s2;
			vm_s3 <= vm_s2;
			ae_s3 <= ae_s2;
			v_s3  <= v_s2;
			zm_s3 <= zm_s2;
			ba_s3 <= ba_s2;
			pcr_s3[0] <= mulq(q16_t'(vm_s2[1]), q16_t'(b_s2[2]));
			pcr_s3[1] <= mulq(q16_t'(vm_s2[2]), q16_t'(b_s2[1]));
			pcr_s3[2] <= mulq(q16_t'(vm_s2[2]), q16_t'(b_s2[0]));
			pcr_s3[3] <= mulq(q16_t'(vm_s2[0]), q16_t'(b_s2[2]));
			pcr_s3[4] <= mulq(q16_t'(vm_s2[0]), q16_t'(b_s2[1]));
			pcr_s3[5] <= mulq(q16_t'(vm_s2[1]), q16_t'(b_s2[0]));
			for (int k = 0; k < 6; k++) begin
				pm_s3[k] <= mulq(sq_s2[k], a2_s2);
			end
			bsq_s3 <= sat32(sxq(sq_s2[0]) + sxq(sq_s2[1]) + sxq(sq_s2[2]));

			a_s4  <= a_s3;
			vm_s4 <= vm_s3;
			ae_s4 <= ae_s3;
			v_s4  <= v_s3;
			zm_s4 <= zm_s3;
			for (int i = 0; i < 3; i++) begin
				c_s4[i] <= sat32(sxq(rsat(pcr_s3[2*i])) - sxq(rsat(pcr_s3[2*i+1])));
			end
			m_s4[0] <= sat32(mb[0] + ONE_Q16);
			m_s4[1] <= sat32(mb[3] + sxq(ba_s3[2]));
			m_s4[2] <= sat32(mb[4] - sxq(ba_s3[1]));
			m_s4[3] <= sat32(mb[3] - sxq(ba_s3[2]));
			m_s4[4] <= sat32(mb[1] + ONE_Q16);
			m_s4[5] <= sat32(mb[5] + sxq(ba_s3[0]));
			m_s4[6] <= sat32(mb[4] + sxq(ba_s3[1]));
			m_s4[7] <= sat32(mb[5] - sxq(ba_s3[0]));
			m_s4[8] <= sat32(mb[2] + ONE_Q16);
			pden_s4 <= mulq(bsq_s3, a2_s3);

			for (int i = 0; i < 3; i++) begin
				pac_s5[i] <= mulq(a_s4, q16_t'(c_s4[i]));
			end
			den_s5 <= sat32(sxw(rnd16(pden_s4)) + ONE_Q16);
			m_s5   <= m_s4;
			vm_s5  <= vm_s4;
			ae_s5  <= ae_s4;
			v_s5   <= v_s4;
			zm_s5  <= zm_s4;

			for (int i = 0; i < 3; i++) begin
				rhs_s6[i] <= sat32(sxq(q16_t'(vm_s5[i])) + sxw(rnd16(pac_s5[i])));
			end
			m_s6   <= m_s5;
			den_s6 <= den_s5;
			ae_s6  <= ae_s5;
			v_s6   <= v_s5;
			zm_s6  <= zm_s5;

			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prm_s7[3*i+j] <= mulq(q16_t'(rhs_s6[j]), m_s6[3*i+j]);
				end
			end
			den_s7 <= den_s6;
			ae_s7  <= ae_s6;
			v_s7   <= v_s6;
			zm_s7  <= zm_s6;

			for (int i = 0; i < 3; i++) begin
				num_s8[i] <= nsum[i][NUM_W-1:0];
			end
			den_s8 <= den_s7;
			ae_s8  <= ae_s7;
			v_s8   <= v_s7;
			zm_s8  <= zm_s7;
		end
	end

	always_comb begin
		rs.v  = v_s8;
		rs.ae = ae_s8;
		rs.zm = zm_s8;
		for (int i = 0; i < 3; i++) begin
			mag[i] = num_s8[i][NUM_W-1] ? -num_s8[i] : num_s8[i];
		end
		d0.num  = {mag[0], {FRAC_W{1'b0}}};
		d0.den  = {1'b0, den_s8};
		d0.neg  = num_s8[0][NUM_W-1];
		d0.side = SIDE_W'(rs);
		d1.num  = {mag[1], {FRAC_W{1'b0}}};
		d1.den  = {1'b0, den_s8};
		d1.neg  = num_s8[1][NUM_W-1];
		d1.side = '0;
		d2.num  = {mag[2], {FRAC_W{1'b0}}};
		d2.den  = {1'b0, den_s8};
		d2.neg  = num_s8[2][NUM_W-1];
		d2.side = '0;
	end

	assign out_valid = vld[8];

endmodule

[rtl/bvp_kick.sv]
// Second electric kick, zero-mass bypass and the output register that
// drives the pipeline advance. Depends on bvp_pkg.
module bvp_kick
	import bvp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  div_out_t r0,
	input  div_out_t r1,
	input  div_out_t r2,
	input  logic     out_ready,
	output logic     adv,
	output logic     out_valid,
	output vec_t     nvel,
	output logic     bad
);

	row_side_t rs;
	vec_t      nv;
	q16_t      quot [3];
	logic      vld_q;
	vec_t      nvel_q;
	logic      bad_q;

	assign rs  = row_side_t'(r0.side[ROW_W-1:0]);
	assign adv = !vld_q || out_ready;

	always_comb begin
		quot[0] = r0.quot;
		quot[1] = r1.quot;
		quot[2] = r2.quot;
		for (int i = 0; i < 3; i++) begin
			nv[i] = sat32(sxq(quot[i]) + sxw(wide_t'(rs.ae[i])));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nvel_q <= rs.zm ? rs.v : nv;
			bad_q  <= rs.zm;
		end
	end

	assign out_valid = vld_q;
	assign nvel      = nvel_q;
	assign bad       = bad_q;

endmodule

[rtl/boris_velocity_push_top.sv]
// Top level of the Boris velocity push: time step register and the chain
// coefficient, divider, rotation, three row dividers and kick.
// Depends on bvp_pkg, bvp_if, bvp_coef, bvp_div, bvp_rot and bvp_kick.
//
//  channel   | dir | word
//  ----------+-----+------------------------------------------------
//  particle  | in  | velocity, E, B, charge and mass of one particle
//  result    | out | new velocity and the zero-mass flag
//  cfg       | in  | full time step, always accepted
//
// One word is taken every cycle unless the output stalls; the dividers
// have 34 stages each and produce one quotient bit per stage.
// Reset clears every valid bit and sets the time step to one.
// When the output register holds a word that is not taken, the whole
// pipeline holds, including the input, and nothing is lost or repeated.
module boris_velocity_push_top
	import bvp_pkg::*;
(
	input logic          clk,
	input logic          arst_n,
	particle_if.sink     particle,
	result_if.source     result,
	cfg_if.sink          cfg
);

	logic [TSTEP_W-1:0] time_step_q;
	logic               adv;
	particle_t          pin;
	logic               coef_valid;
	div_in_t            coef_div;
	logic               a_valid;
	div_out_t           a_out;
	logic               rot_valid;
	div_in_t            rd0, rd1, rd2;
	logic               rv0, rv1, rv2;
	div_out_t           ro0, ro1, ro2;
	vec_t               nvel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= TSTEP_RESET;
		end else if (cfg.valid) begin
			time_step_q <= cfg.time_step;
		end
	end

	assign cfg.ready      = 1'b1;
	assign particle.ready = adv;

	always_comb begin
		pin.v      = {particle.vel_z, particle.vel_y, particle.vel_x};
		pin.e      = {particle.efield_z, particle.efield_y, particle.efield_x};
		pin.b      = {particle.bfield_z, particle.bfield_y, particle.bfield_x};
		pin.charge = particle.charge;
		pin.mass   = particle.mass;
	end

	bvp_coef u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (particle.valid),
		.pin       (pin),
		.half_step (time_step_q[TSTEP_W-1:1]),
		.out_valid (coef_valid),
		.dout      (coef_div)
	);

	bvp_div u_div_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (coef_valid),
		.din       (coef_div),
		.out_valid (a_valid),
		.dout      (a_out)
	);

	bvp_rot u_rot (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (a_valid),
		.din       (a_out),
		.out_valid (rot_valid),
		.d0        (rd0),
		.d1        (rd1),
		.d2        (rd2)
	);

	bvp_div u_div_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (rot_valid),
		.din       (rd0),
		.out_valid (rv0),
		.dout      (ro0)
	);

	bvp_div u_div_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (rot_valid),
		.din       (rd1),
		.out_valid (rv1),
		.dout      (ro1)
	);

	bvp_div u_div_z (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (rot_valid),
		.din       (rd2),
		.out_valid (rv2),
		.dout      (ro2)
	);

	bvp_kick u_kick (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rv0 & rv1 & rv2),
		.r0        (ro0),
		.r1        (ro1),
		.r2        (ro2),
		.out_ready (result.ready),
		.adv       (adv),
		.out_valid (result.valid),
		.nvel      (nvel),
		.bad       (result.bad_mass)
	);

	assign result.new_vel_x = nvel[0];
	assign result.new_vel_y = nvel[1];
	assign result.new_vel_z = nvel[2];

endmodule
